// ===== rtl/lkvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key/value cache
// Sizes, field packing, operation codes and the structs that pass between
// the store and the top level.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int RANK_BITS  = IDX_BITS;
    localparam int COUNT_BITS = $clog2(ENTRIES + 1);

    // stream packing, rounded up to whole bytes
    localparam int S_DATA_BITS = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((VALUE_BITS + KEY_BITS + 7) / 8) * 8;
    localparam int S_USER_BITS = 8;
    localparam int M_USER_BITS = 8;

    // configuration port
    localparam int                  APB_ADDR_BITS = 3;
    localparam int                  APB_DATA_BITS = 32;
    localparam int                  CAP_BITS      = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET     = CAP_BITS'(16);
    localparam logic                REG_CAPACITY  = 1'b0;

    // operation codes
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } lkvc_req_t;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted;
        logic [KEY_BITS-1:0]   evicted_key;
    } lkvc_result_t;

endpackage

// ===== rtl/lkvc_apb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_apb_regs: configuration register block
// Holds the capacity register behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
module lkvc_apb_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lkvc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [lkvc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [lkvc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output logic [lkvc_pkg::CAP_BITS-1:0]       capacity
);

    logic [lkvc_pkg::CAP_BITS-1:0] capacity_reg;
    logic                          reg_sel;
    logic                          wr_en;

    // register index is the word address
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready && (reg_sel == lkvc_pkg::REG_CAPACITY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lkvc_pkg::CAP_RESET;
        end else if (wr_en) begin
            capacity_reg <= pwdata[lkvc_pkg::CAP_BITS-1:0];
        end
    end

    always_comb begin
        if (reg_sel == lkvc_pkg::REG_CAPACITY) begin
            prdata = lkvc_pkg::APB_DATA_BITS'(capacity_reg);
        end else begin
            prdata = '0;
        end
    end

    assign capacity = capacity_reg;

endmodule

// ===== rtl/lkvc_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_store: entry array with parallel lookup and recency ranks
// Compares the key against every entry at once, picks the hit, least recent
// or first free slot and updates keys, values and ranks on a request.
// ----------------------------------------------------------------------------
module lkvc_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          req_fire,
    input  lkvc_pkg::lkvc_req_t           req,
    input  logic [lkvc_pkg::CAP_BITS-1:0] capacity,
    output lkvc_pkg::lkvc_result_t        result
);

    localparam int N  = lkvc_pkg::ENTRIES;
    localparam int RB = lkvc_pkg::RANK_BITS;
    localparam int CB = lkvc_pkg::COUNT_BITS;

    logic [lkvc_pkg::KEY_BITS-1:0]   key_reg   [N];
    logic [lkvc_pkg::VALUE_BITS-1:0] value_reg [N];
    logic [RB-1:0]                   rank_reg  [N];
    logic [N-1:0]                    valid_reg;
    logic [CB-1:0]                   count_reg;

    logic [N-1:0]                    match;
    logic [N-1:0]                    lru_oh;
    logic [N-1:0]                    free_vec;
    logic [N-1:0]                    free_oh;
    logic [N-1:0]                    ins_oh;
    logic [RB-1:0]                   lru_rank;
    logic [RB-1:0]                   hit_rank;
    logic [lkvc_pkg::VALUE_BITS-1:0] hit_value;
    logic [lkvc_pkg::KEY_BITS-1:0]   lru_key;
    logic [CB-1:0]                   eff_cap;
    logic                            hit;
    logic                            is_put;
    logic                            evict;

    // clamp capacity into 1..ENTRIES
    always_comb begin
        if (capacity == '0) begin
            eff_cap = CB'(1);
        end else if (32'(capacity) > 32'(N)) begin
            eff_cap = CB'(N);
        end else begin
            eff_cap = CB'(capacity);
        end
    end

    // valid ranks form 0..count-1, so the least recent holds count-1
    assign lru_rank = RB'(count_reg - CB'(1));
    assign free_vec = ~valid_reg;
    assign free_oh  = free_vec & (~free_vec + N'(1));

    always_comb begin
        hit_rank  = '0;
        hit_value = '0;
        lru_key   = '0;
        for (int i = 0; i < N; i++) begin
            match[i]  = valid_reg[i] && (key_reg[i] == req.key);
            lru_oh[i] = valid_reg[i] && (rank_reg[i] == lru_rank);
            if (match[i]) begin
                hit_rank  = hit_rank | rank_reg[i];
                hit_value = hit_value | value_reg[i];
            end
            if (lru_oh[i]) begin
                lru_key = lru_key | key_reg[i];
            end
        end
    end

    assign hit    = |match;
    assign is_put = (req.action == lkvc_pkg::ACT_PUT);
    assign evict  = is_put && !hit && (count_reg >= eff_cap) && (count_reg != '0);
    assign ins_oh = evict ? lru_oh : free_oh;

    always_comb begin
        result.hit         = hit;
        result.read_value  = (hit && !is_put) ? hit_value : '0;
        result.evicted     = evict;
        result.evicted_key = evict ? lru_key : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < N; i++) begin
                rank_reg[i] <= '0;
            end
        end else if (req_fire) begin
            if (hit) begin
                // move the hit entry to the front, age the ones ahead of it
                for (int i = 0; i < N; i++) begin
                    if (match[i]) begin
                        rank_reg[i] <= '0;
                    end else if (valid_reg[i] && (rank_reg[i] < hit_rank)) begin
                        rank_reg[i] <= rank_reg[i] + RB'(1);
                    end
                end
            end else if (is_put) begin
                for (int i = 0; i < N; i++) begin
                    if (ins_oh[i]) begin
                        rank_reg[i] <= '0;
                    end else if (valid_reg[i]) begin
                        rank_reg[i] <= rank_reg[i] + RB'(1);
                    end
                end
                valid_reg <= valid_reg | ins_oh;
                if (!evict && (ins_oh != '0)) begin
                    count_reg <= count_reg + CB'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_fire && is_put) begin
            for (int i = 0; i < N; i++) begin
                if (hit ? match[i] : ins_oh[i]) begin
                    value_reg[i] <= req.value;
                end
                if (!hit && ins_oh[i]) begin
                    key_reg[i] <= req.key;
                end
            end
        end
    end

endmodule

// ===== rtl/lru_key_value_cache_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative LRU key/value cache
//
//  channel  | direction | transfer contents
//  ---------+-----------+--------------------------------------------------
//  s_       | in        | tuser: action; tdata: key, value
//  m_       | out       | tuser: hit, evicted; tdata: read_value, evicted_key
//  APB      | in/out    | capacity register at byte address 0
//
// One item per cycle sustained while the result stream does not stall; the
// result passes through the input register and then the result register,
// around the combinational lookup and the registered update of the entry
// array.
// Reset is synchronous and active low; it empties the cache and sets capacity
// to 16. A stalled result holds the result register, and the input register
// keeps accepting until it also holds an item.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lkvc_pkg::S_DATA_BITS-1:0]    s_tdata,   // key, value
    input  logic [lkvc_pkg::S_USER_BITS-1:0]    s_tuser,   // action
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lkvc_pkg::M_DATA_BITS-1:0]    m_tdata,   // read_value, evicted_key
    output logic [lkvc_pkg::M_USER_BITS-1:0]    m_tuser,   // hit, evicted
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lkvc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [lkvc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [lkvc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    localparam int KB = lkvc_pkg::KEY_BITS;
    localparam int VB = lkvc_pkg::VALUE_BITS;

    logic                          in_valid_reg;
    lkvc_pkg::lkvc_req_t           in_req_reg;
    logic                          out_valid_reg;
    lkvc_pkg::lkvc_result_t        out_res_reg;
    lkvc_pkg::lkvc_result_t        result;
    logic [lkvc_pkg::CAP_BITS-1:0] capacity;
    logic                          advance;
    logic                          s_fire;

    lkvc_apb_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    lkvc_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_fire (advance),
        .req      (in_req_reg),
        .capacity (capacity),
        .result   (result)
    );

    // advance when the result register is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_reg.action <= s_tuser[0];
            in_req_reg.key    <= s_tdata[KB-1:0];
            in_req_reg.value  <= s_tdata[KB+VB-1:KB];
        end
        if (advance) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = lkvc_pkg::M_DATA_BITS'({out_res_reg.evicted_key, out_res_reg.read_value});
    assign m_tuser  = lkvc_pkg::M_USER_BITS'({out_res_reg.evicted, out_res_reg.hit});

endmodule

// ===== rtl/lkvc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_port_checker: port-level checks for the LRU key/value cache
// Watches the result stream for consistent flags and payload.
// ----------------------------------------------------------------------------
module lkvc_port_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [lkvc_pkg::M_DATA_BITS-1:0]    m_tdata,
    input logic [lkvc_pkg::M_USER_BITS-1:0]    m_tuser
);

    localparam int KB = lkvc_pkg::KEY_BITS;
    localparam int VB = lkvc_pkg::VALUE_BITS;

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // an eviction only comes from a put that missed, so hit and evicted are never both set
    a_evict_not_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("hit and evicted both set");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata[VB-1:0] == '0))
        else $error("read_value nonzero on a miss");

    a_no_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> (m_tdata[VB+KB-1:VB] == '0))
        else $error("evicted_key nonzero without eviction");

    // no result can be ready on the first cycle out of reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_tvalid)
        else $error("result offered right after reset");

endmodule

bind lru_key_value_cache_unit lkvc_port_checker u_lkvc_checker (.*);
